FILE: sv/riff_wave_header_parser_assert.svh
// Assertion macros for the RIFF/WAVE header parser
`ifndef RIFF_WAVE_HEADER_PARSER_ASSERT_SVH
`define RIFF_WAVE_HEADER_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF

`define RWHP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rwhp assertion failed");

`define RWHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rwhp assertion failed");

`else

`define RWHP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)

`define RWHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/rwhp_pkg.sv
`timescale 1ns / 1ps

package rwhp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'd1179011410;
    localparam logic [31:0] TAG_WAVE = 32'd1163280727;
    localparam logic [31:0] TAG_FMT  = 32'd544501094;
    localparam logic [31:0] TAG_DATA = 32'd1635017060;

    // controller -> datapath
    typedef struct packed {
        logic       shift_tag;
        logic       shift_size;
        logic       capture;
        logic [3:0] cap_addr;
        logic       dec_skip;
        logic       div_start;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic tag_wave;
        logic tag_riff;
        logic tag_fmt;
        logic tag_data;
        logic size_nz;
        logic skip_one;
        logic div_busy;
    } t_sts;

    // packed so that format_type lands in the lowest bits
    typedef struct packed {
        logic [31:0] frame_count;
        logic [31:0] data_size;
        logic [15:0] bit_depth;
        logic [15:0] block_align;
        logic [31:0] byte_rate;
        logic [31:0] sample_rate;
        logic [15:0] channel_count;
        logic [15:0] format_type;
    } t_result;

endpackage

FILE: sv/rwhp_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module rwhp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_quot;
    logic [15:0] r_rem;
    logic [15:0] r_div;

    logic [16:0] w_sh;
    logic [16:0] w_diff;
    logic        w_ge;

    assign w_sh   = {r_rem, r_quot[31]};
    assign w_diff = w_sh - {1'b0, r_div};
    assign w_ge   = w_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[15:0] : w_sh[15:0];
            r_quot <= {r_quot[30:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

FILE: sv/rwhp_dp.sv
`timescale 1ns / 1ps

module rwhp_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_byte,
    input  rwhp_pkg::t_cmd   i_cmd,
    output rwhp_pkg::t_sts   o_sts,
    output logic             o_done,
    output rwhp_pkg::t_result o_res,
    output logic             o_align_zero
);

    logic [31:0] r_tag;
    logic [31:0] r_skip;
    logic [31:0] r_data_size;
    logic [7:0]  r_fmt [16];

    logic [31:0] w_tag_nx;
    logic [31:0] w_size_nx;
    logic [15:0] w_align;
    logic        w_busy;
    logic [31:0] w_quot;

    assign w_tag_nx  = {i_byte, r_tag[31:8]};
    assign w_size_nx = {i_byte, r_skip[31:8]};
    assign w_align   = {r_fmt[13], r_fmt[12]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_tag) begin
            r_tag <= w_tag_nx;
        end
        if (i_cmd.shift_size) begin
            r_skip <= w_size_nx;
        end else if (i_cmd.dec_skip) begin
            r_skip <= r_skip - 32'd1;
        end
        if (i_cmd.div_start) begin
            r_data_size <= w_size_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_fmt[i] <= '0;
            end
        end else if (i_cmd.capture) begin
            r_fmt[i_cmd.cap_addr] <= i_byte;
        end
    end

    rwhp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_size_nx),
        .i_divisor  (w_align),
        .o_busy     (w_busy),
        .o_done     (o_done),
        .o_quotient (w_quot)
    );

    always_comb begin
        o_sts.tag_wave = w_tag_nx == rwhp_pkg::TAG_WAVE;
        o_sts.tag_riff = w_tag_nx == rwhp_pkg::TAG_RIFF;
        o_sts.tag_fmt  = w_tag_nx == rwhp_pkg::TAG_FMT;
        o_sts.tag_data = w_tag_nx == rwhp_pkg::TAG_DATA;
        o_sts.size_nz  = w_size_nx != 32'd0;
        o_sts.skip_one = r_skip == 32'd1;
        o_sts.div_busy = w_busy;
    end

    always_comb begin
        o_res.format_type   = {r_fmt[1], r_fmt[0]};
        o_res.channel_count = {r_fmt[3], r_fmt[2]};
        o_res.sample_rate   = {r_fmt[7], r_fmt[6], r_fmt[5], r_fmt[4]};
        o_res.byte_rate     = {r_fmt[11], r_fmt[10], r_fmt[9], r_fmt[8]};
        o_res.block_align   = w_align;
        o_res.bit_depth     = {r_fmt[15], r_fmt[14]};
        o_res.data_size     = r_data_size;
        o_res.frame_count   = (w_align == 16'd0) ? 32'd0 : w_quot;
        o_align_zero        = w_align == 16'd0;
    end

endmodule

FILE: sv/rwhp_ctrl.sv
`timescale 1ns / 1ps

module rwhp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_start,
    input  logic           i_out_pend,
    input  rwhp_pkg::t_sts i_sts,
    output logic           o_ready,
    output rwhp_pkg::t_cmd o_cmd
);

    localparam logic [1:0] PH_TAG  = 2'd0;
    localparam logic [1:0] PH_SIZE = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;
    localparam logic [1:0] PH_IDLE = 2'd3;

    localparam logic [1:0] KIND_RIFF  = 2'd0;
    localparam logic [1:0] KIND_FMT   = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    localparam logic [4:0] FMT_BYTES = 5'd16;

    logic [1:0] r_phase, n_phase;
    logic [1:0] r_pos, n_pos;
    logic [1:0] r_kind, n_kind;
    logic [4:0] r_cap, n_cap;

    logic [1:0] e_phase, e_pos, e_kind;
    logic [4:0] e_cap;
    logic       w_emit_next;
    logic       w_accept;

    // a result could come from the next request
    assign w_emit_next = (r_phase == PH_SIZE) && (r_pos == 2'd3) && (r_kind == KIND_DATA);
    assign o_ready     = !i_sts.div_busy && !(i_out_pend && w_emit_next);
    assign w_accept    = i_valid && o_ready;

    always_comb begin
        e_phase = r_phase;
        e_pos   = r_pos;
        e_kind  = r_kind;
        e_cap   = r_cap;
        if (i_start) begin
            e_phase = PH_TAG;
            e_pos   = 2'd0;
            e_kind  = KIND_RIFF;
            e_cap   = 5'd0;
        end

        n_phase = r_phase;
        n_pos   = r_pos;
        n_kind  = r_kind;
        n_cap   = r_cap;
        o_cmd   = '0;

        if (w_accept) begin
            n_phase = e_phase;
            n_pos   = e_pos;
            n_kind  = e_kind;
            n_cap   = e_cap;
            case (e_phase)
                PH_TAG: begin
                    o_cmd.shift_tag = 1'b1;
                    n_pos = e_pos + 2'd1;
                    if (e_pos == 2'd3 && !i_sts.tag_wave) begin
                        n_phase = PH_SIZE;
                        if (i_sts.tag_riff) begin
                            n_kind = KIND_RIFF;
                        end else if (i_sts.tag_fmt) begin
                            n_kind = KIND_FMT;
                        end else if (i_sts.tag_data) begin
                            n_kind = KIND_DATA;
                        end else begin
                            n_kind = KIND_OTHER;
                        end
                    end
                end
                PH_SIZE: begin
                    o_cmd.shift_size = 1'b1;
                    n_pos = e_pos + 2'd1;
                    if (e_pos == 2'd3) begin
                        case (e_kind)
                            KIND_DATA: begin
                                o_cmd.div_start = 1'b1;
                                n_phase = PH_IDLE;
                            end
                            KIND_RIFF: begin
                                n_phase = PH_TAG;
                            end
                            default: begin
                                n_cap   = 5'd0;
                                n_phase = i_sts.size_nz ? PH_BODY : PH_TAG;
                            end
                        endcase
                    end
                end
                PH_BODY: begin
                    o_cmd.dec_skip = 1'b1;
                    if (e_kind == KIND_FMT && e_cap < FMT_BYTES) begin
                        o_cmd.capture  = 1'b1;
                        o_cmd.cap_addr = e_cap[3:0];
                        n_cap = e_cap + 5'd1;
                    end
                    if (i_sts.skip_one) begin
                        n_phase = PH_TAG;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_pos   <= 2'd0;
            r_kind  <= KIND_RIFF;
            r_cap   <= 5'd0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_kind  <= n_kind;
            r_cap   <= n_cap;
        end
    end

endmodule

FILE: sv/riff_wave_header_parser.sv
`timescale 1ns / 1ps
// RIFF/WAVE header parser.
// Input channel (s_*): one file byte per request in tdata, tuser high on the
// first byte of a new file, which restarts the parse. Bytes are taken one per
// cycle while the header is walked; format, size and unknown chunks all pass
// at that rate.
// Output channel (m_*): one request per file, sent after the size word of the
// data chunk: format fields, data size and frame count in tdata, zero block
// alignment flag in tuser.
// The frame count comes from a one-bit-per-cycle divider started by the last
// data size byte; input stalls while it runs, and its quotient is registered
// into the output once done. Bytes after the result are dropped until the
// next start byte.
// A result waiting on a stalled receiver does not block input: only the byte
// that would produce the next result is held back until the output is taken.
// Reset (synchronous, active low) returns the parser to tag reading, clears
// the stored format fields and empties the output register.
`include "riff_wave_header_parser_assert.svh"

module riff_wave_header_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // file_byte
    input  logic         i_s_tuser,   // start_req
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // format_type, channel_count, sample_rate, byte_rate, block_align,
    // bit_depth, data_size, frame_count
    output logic [191:0] o_m_tdata,
    output logic         o_m_tuser    // align_zero
);

    rwhp_pkg::t_cmd    w_cmd;
    rwhp_pkg::t_sts    w_sts;
    rwhp_pkg::t_result w_res;
    logic              w_done;
    logic              w_align_zero;

    logic              r_out_valid;
    rwhp_pkg::t_result r_res;
    logic              r_align_zero;

    rwhp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .i_start    (i_s_tuser),
        .i_out_pend (r_out_valid),
        .i_sts      (w_sts),
        .o_ready    (o_s_tready),
        .o_cmd      (w_cmd)
    );

    rwhp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_s_tdata),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_done       (w_done),
        .o_res        (w_res),
        .o_align_zero (w_align_zero)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_res        <= w_res;
            r_align_zero <= w_align_zero;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_res;
    assign o_m_tuser  = r_align_zero;

    `RWHP_ASSERT_NOW(a_no_take_while_div, i_clk, i_rst_n, w_sts.div_busy, !o_s_tready)
    `RWHP_ASSERT_NOW(a_out_free_at_done, i_clk, i_rst_n, w_done, !r_out_valid)
    `RWHP_ASSERT_NOW(a_zero_cnt, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tdata[191:160] == '0)
    `RWHP_ASSERT_NEXT(a_div_after_start, i_clk, i_rst_n, w_cmd.div_start, w_sts.div_busy)

endmodule

FILE: dv/riff_wave_header_parser_checker.sv
`timescale 1ns / 1ps

module riff_wave_header_parser_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [7:0]   i_s_tdata,   // file_byte
    input  logic         i_s_tuser,   // start_req
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    // format_type, channel_count, sample_rate, byte_rate, block_align,
    // bit_depth, data_size, frame_count
    input  logic [191:0] i_m_tdata,
    input  logic         i_m_tuser,   // align_zero
    output int           o_fail_count,
    output int           o_pending,
    output int           o_headers_seen,
    output int           o_bytes_seen
);

    typedef enum logic [1:0] {WALK_TAG, WALK_SIZE, WALK_BODY, WALK_IDLE} t_walk;
    typedef enum logic [1:0] {CHUNK_RIFF, CHUNK_FMT, CHUNK_DATA, CHUNK_OTHER} t_chunk;

    typedef struct packed {
        rwhp_pkg::t_result fields;
        logic              align_zero;
    } t_header;

    t_walk       walk;
    logic [31:0] tag_word;
    logic [1:0]  word_pos;
    t_chunk      chunk;
    logic [31:0] bytes_left;
    logic [4:0]  fmt_pos;
    logic [7:0]  fmt_bytes [16];
    logic        file_done;
    t_header     expected_headers [$];

    function automatic void restart_walk();
        walk       = WALK_TAG;
        tag_word   = '0;
        word_pos   = '0;
        chunk      = CHUNK_RIFF;
        bytes_left = '0;
        fmt_pos    = '0;
        file_done  = 1'b0;
    endfunction

    function automatic void walk_header_byte(input logic [7:0] b, input logic first);
        t_header     hdr;
        logic [15:0] align;
        if (first)
            restart_walk();
        if (file_done || walk == WALK_IDLE)
            return;
        case (walk)
            WALK_TAG: begin
                tag_word = {b, tag_word[31:8]};
                word_pos = word_pos + 2'd1;
                if (word_pos == 2'd0 && tag_word != rwhp_pkg::TAG_WAVE) begin
                    case (tag_word)
                        rwhp_pkg::TAG_RIFF: chunk = CHUNK_RIFF;
                        rwhp_pkg::TAG_FMT:  chunk = CHUNK_FMT;
                        rwhp_pkg::TAG_DATA: chunk = CHUNK_DATA;
                        default:            chunk = CHUNK_OTHER;
                    endcase
                    bytes_left = '0;
                    walk = WALK_SIZE;
                end
            end
            WALK_SIZE: begin
                bytes_left = {b, bytes_left[31:8]};
                word_pos = word_pos + 2'd1;
                if (word_pos == 2'd0) begin
                    if (chunk == CHUNK_DATA) begin
                        align = {fmt_bytes[13], fmt_bytes[12]};
                        hdr.fields.format_type   = {fmt_bytes[1], fmt_bytes[0]};
                        hdr.fields.channel_count = {fmt_bytes[3], fmt_bytes[2]};
                        hdr.fields.sample_rate   = {fmt_bytes[7], fmt_bytes[6],
                                                    fmt_bytes[5], fmt_bytes[4]};
                        hdr.fields.byte_rate     = {fmt_bytes[11], fmt_bytes[10],
                                                    fmt_bytes[9], fmt_bytes[8]};
                        hdr.fields.block_align   = align;
                        hdr.fields.bit_depth     = {fmt_bytes[15], fmt_bytes[14]};
                        hdr.fields.data_size     = bytes_left;
                        hdr.fields.frame_count   = (align == 16'd0) ? 32'd0
                                                   : bytes_left / {16'd0, align};
                        hdr.align_zero           = (align == 16'd0);
                        expected_headers.push_back(hdr);
                        file_done = 1'b1;
                        walk = WALK_IDLE;
                    end else if (chunk == CHUNK_RIFF) begin
                        walk = WALK_TAG;
                    end else begin
                        fmt_pos = '0;
                        walk = (bytes_left != 32'd0) ? WALK_BODY : WALK_TAG;
                    end
                end
            end
            WALK_BODY: begin
                // short fmt chunks leave the upper store bytes from earlier files
                if (chunk == CHUNK_FMT && fmt_pos < 5'd16) begin
                    fmt_bytes[fmt_pos[3:0]] = b;
                    fmt_pos = fmt_pos + 5'd1;
                end
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 32'd0)
                    walk = WALK_TAG;
            end
            default: ;
        endcase
    endfunction

    function automatic int field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_header           want;
        rwhp_pkg::t_result got;
        int                bad;
        if (!i_rst_n) begin
            restart_walk();
            for (int i = 0; i < 16; i++)
                fmt_bytes[i] = 8'd0;
            expected_headers.delete();
            o_fail_count   <= 0;
            o_pending      <= 0;
            o_headers_seen <= 0;
            o_bytes_seen   <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                walk_header_byte(i_s_tdata, i_s_tuser);
                o_bytes_seen <= o_bytes_seen + 1;
            end
            if (i_m_tvalid && i_m_tready) begin
                o_headers_seen <= o_headers_seen + 1;
                bad = 0;
                if (expected_headers.size() == 0) begin
                    $display("%0t: header request with none expected, actual %h / %b",
                             $time, i_m_tdata, i_m_tuser);
                    bad = 1;
                end else begin
                    want = expected_headers.pop_front();
                    got  = rwhp_pkg::t_result'(i_m_tdata);
                    bad = field_differs("format_type", 32'(want.fields.format_type),
                                        32'(got.format_type))
                        + field_differs("channel_count", 32'(want.fields.channel_count),
                                        32'(got.channel_count))
                        + field_differs("sample_rate", want.fields.sample_rate,
                                        got.sample_rate)
                        + field_differs("byte_rate", want.fields.byte_rate, got.byte_rate)
                        + field_differs("block_align", 32'(want.fields.block_align),
                                        32'(got.block_align))
                        + field_differs("bit_depth", 32'(want.fields.bit_depth),
                                        32'(got.bit_depth))
                        + field_differs("data_size", want.fields.data_size, got.data_size)
                        + field_differs("frame_count", want.fields.frame_count,
                                        got.frame_count)
                        + field_differs("align_zero", 32'(want.align_zero),
                                        32'(i_m_tuser));
                end
                if (bad != 0)
                    o_fail_count <= o_fail_count + 1;
            end
            o_pending <= expected_headers.size();
        end
    end

endmodule

FILE: dv/riff_wave_header_parser_tb.sv
`timescale 1ns / 1ps

module riff_wave_header_parser_tb;

    localparam int ITEM_TARGET   = 1500;
    localparam int PHASE_BYTES   = 380;
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 600;
    localparam int TAIL_CYCLES   = 60;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle;

    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic [7:0]   i_s_tdata  = 8'd0;   // file_byte
    logic         i_s_tuser  = 1'b0;   // start_req
    logic         i_m_tready = 1'b0;
    logic         o_s_tready;
    logic         o_m_tvalid;
    logic [191:0] o_m_tdata;           // format_type .. frame_count
    logic         o_m_tuser;           // align_zero

    int    fail_count;
    int    pending;
    int    headers_seen;
    int    bytes_seen;
    t_idle idle_mode = IDLE_NONE;
    int    bytes_sent = 0;
    int    files_sent = 0;
    int    hold_left;
    logic  hold_done;

    logic [7:0] wav_bytes [$];
    logic       wav_noise;

    always #5 i_clk = ~i_clk;

    riff_wave_header_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    riff_wave_header_parser_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_tvalid),
        .i_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .i_s_tuser      (i_s_tuser),
        .i_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .i_m_tdata      (o_m_tdata),
        .i_m_tuser      (o_m_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_headers_seen (headers_seen),
        .o_bytes_seen   (bytes_seen)
    );

    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    // one long hold-off early on so the parser backs up against a waiting header
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
        end else if (hold_left != 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (!hold_done && bytes_seen >= HOLD_AT) begin
            i_m_tready <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_done  <= 1'b1;
        end else if (idle_mode == IDLE_RECEIVER) begin
            i_m_tready <= ($urandom_range(99) >= 53);
        end else if (idle_mode == IDLE_BOTH) begin
            i_m_tready <= ($urandom_range(99) >= 37);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    function automatic void add_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            wav_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void add_junk_chunk();
        int unsigned len;
        len = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        add_word($urandom);
        add_word(len);
        for (int i = 0; i < len; i++)
            wav_bytes.push_back(8'($urandom));
    endfunction

    function automatic void add_fmt_chunk();
        int unsigned len;
        int unsigned fill;
        logic [15:0] align;
        logic [7:0]  v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: len = 16;
            6, 7:             len = $urandom_range(0, 15);
            default:          len = $urandom_range(17, 24);
        endcase
        case ($urandom_range(5))
            0:       align = 16'd0;
            1:       align = 16'd1;
            2:       align = 16'd2;
            3:       align = 16'd4;
            4:       align = 16'hFFFF;
            default: align = 16'($urandom);
        endcase
        fill = $urandom_range(7);
        add_word(rwhp_pkg::TAG_FMT);
        add_word(len);
        for (int i = 0; i < len; i++) begin
            if (fill == 0)
                v = 8'h00;
            else if (fill == 1)
                v = 8'hFF;
            else if (i == 12)
                v = align[7:0];
            else if (i == 13)
                v = align[15:8];
            else
                v = 8'($urandom);
            wav_bytes.push_back(v);
        end
    endfunction

    function automatic logic [31:0] pick_data_size();
        case ($urandom_range(4))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 4096);
            default: return $urandom;
        endcase
    endfunction

    function automatic void build_random_file();
        int unsigned cut;
        wav_bytes.delete();
        wav_noise = ($urandom_range(99) < 6);
        if (wav_noise) begin
            repeat ($urandom_range(1, 24))
                wav_bytes.push_back(8'($urandom));
            return;
        end
        if ($urandom_range(3) != 0) begin
            add_word(rwhp_pkg::TAG_RIFF);
            add_word($urandom);
        end
        if ($urandom_range(3) != 0)
            add_word(rwhp_pkg::TAG_WAVE);
        if ($urandom_range(4) == 0)
            add_junk_chunk();
        if ($urandom_range(9) != 0)
            add_fmt_chunk();
        if ($urandom_range(3) == 0)
            add_junk_chunk();
        if ($urandom_range(19) != 0) begin
            add_word(rwhp_pkg::TAG_DATA);
            add_word(pick_data_size());
        end
        // bytes after the header are ignored
        repeat ($urandom_range(0, 3))
            wav_bytes.push_back(8'($urandom));
        if ($urandom_range(9) == 0 && wav_bytes.size() > 1) begin
            cut = $urandom_range(1, wav_bytes.size() - 1);
            repeat (cut)
                void'(wav_bytes.pop_back());
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic first);
        while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 53) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < 37)) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= first;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < wav_bytes.size(); i++)
            send_byte(wav_bytes[i], (i == 0) || (wav_noise && $urandom_range(7) == 0));
        files_sent++;
    endtask

    task automatic wait_for_headers();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_idle next_mode;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // data chunk straight away with a cleared format store: zero alignment
        wav_noise = 1'b0;
        wav_bytes.delete();
        add_word(rwhp_pkg::TAG_DATA);
        add_word(32'd0);
        send_file();
        // dropped until the next start
        send_byte(8'hA5, 1'b0);
        wav_bytes.delete();
        add_word(rwhp_pkg::TAG_RIFF);
        add_word(32'hFFFF_FFFF);
        add_word(rwhp_pkg::TAG_DATA);
        add_word(32'hFFFF_FFFF);
        send_file();

        while (bytes_sent < ITEM_TARGET) begin
            next_mode = t_idle'((bytes_sent / PHASE_BYTES) % 4);
            if (next_mode != idle_mode) begin
                wait_for_headers();
                idle_mode = next_mode;
            end
            build_random_file();
            send_file();
        end

        wait_for_headers();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Streamed %0d file bytes in %0d files under four idling patterns,",
                 bytes_sent, files_sent);
        $display("with one long output hold-off; %0d parsed headers compared.",
                 headers_seen);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/rwhp_pkg.sv
sv/rwhp_div.sv
sv/rwhp_dp.sv
sv/rwhp_ctrl.sv
sv/riff_wave_header_parser.sv
dv/riff_wave_header_parser_checker.sv
dv/riff_wave_header_parser_tb.sv
